>>> design/pgsv_pkg.sv
// ----------------------------------------------------------------------------
// Pauli gate state vector package
// Shared constants, request and result types and the saturating negation.
// ----------------------------------------------------------------------------
package pgsv_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int AMP_BITS   = 16;
    localparam int ADDR_W     = MAX_QUBITS;
    localparam int PAIR_W     = MAX_QUBITS - 1;
    localparam int MEM_DEPTH  = 1 << MAX_QUBITS;
    localparam int WORD_W     = 2 * AMP_BITS;
    localparam int OP_W       = 3;
    localparam int QCNT_W     = 4;

    localparam logic [QCNT_W-1:0] QCNT_RESET = QCNT_W'(MAX_QUBITS);
    localparam logic [QCNT_W-1:0] QCNT_MAX   = QCNT_W'(MAX_QUBITS);

    localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_W-1:0] OP_READ = 3'd1;
    localparam logic [OP_W-1:0] OP_X    = 3'd2;
    localparam logic [OP_W-1:0] OP_Y    = 3'd3;
    localparam logic [OP_W-1:0] OP_Z    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [ADDR_W-1:0]          address;
        logic signed [AMP_BITS-1:0] real_in;
        logic signed [AMP_BITS-1:0] imag_in;
        logic [QCNT_W-1:0]          qubit;
    } t_in;

    typedef struct packed {
        logic signed [AMP_BITS-1:0] real_out;
        logic signed [AMP_BITS-1:0] imag_out;
    } t_out;

    function automatic logic [AMP_BITS-1:0] f_neg(input logic [AMP_BITS-1:0] v);
        logic [AMP_BITS-1:0] min_val;
        min_val = {1'b1, {(AMP_BITS-1){1'b0}}};
        if (v == min_val) begin
            f_neg = ~min_val;
        end else begin
            f_neg = AMP_BITS'(~v + AMP_BITS'(1));
        end
    endfunction

endpackage

>>> design/pgsv_ram.sv
// ----------------------------------------------------------------------------
// Pauli gate state vector RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pgsv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pauli_gate_state_vector.sv
// ----------------------------------------------------------------------------
// Pauli gate state vector
// Stored complex state vector with load, read and Pauli X, Y, Z gate requests.
// ----------------------------------------------------------------------------
// Requests enter on the input channel and read results leave on the output
// channel, both with valid and ready. The qubit count is written on the
// configuration channel, which is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce. A read
// passes through the registered memory read port into the output register;
// the next request may be accepted as soon as the block is idle again, even
// while that result waits. A gate on an n-qubit vector makes two reads of
// every amplitude pair through the single read port of the amplitude
// memory, and the pipeline drains at the end. No request is accepted while
// a gate runs. After reset the qubit count is ten and the memory content is
// undefined until loaded. While the receiver stalls the read result is
// held, and a further read request waits until the output register is free.
// ----------------------------------------------------------------------------
module pauli_gate_state_vector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pgsv_pkg::t_in                i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pgsv_pkg::t_out               o_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pgsv_pkg::QCNT_W-1:0]  i_cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RD    = 2'd1;
    localparam logic [1:0] S_GATE  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    localparam int AW = pgsv_pkg::ADDR_W;
    localparam int PW = pgsv_pkg::PAIR_W;
    localparam int AB = pgsv_pkg::AMP_BITS;
    localparam int WW = pgsv_pkg::WORD_W;
    localparam int QW = pgsv_pkg::QCNT_W;

    logic [1:0]          r_state, n_state;
    logic [QW-1:0]       r_qcnt;
    logic [pgsv_pkg::OP_W-1:0] r_op, n_op;
    logic [QW-1:0]       r_q, n_q;
    logic [PW-1:0]       r_cnt, n_cnt;
    logic [PW-1:0]       r_last, n_last;
    logic                r_ph, n_ph;
    logic                r_s1_vld, n_s1_vld;
    logic                r_s1_ph, n_s1_ph;
    logic [AW-1:0]       r_s1_addr, n_s1_addr;
    logic [AB-1:0]       r_lo_re, r_lo_im;
    logic [AW-1:0]       r_lo_addr;
    logic                r_wh_vld, n_wh_vld;
    logic [AW-1:0]       r_wh_addr;
    logic [WW-1:0]       r_wh_data, n_wh_data;
    logic                r_out_vld, n_out_vld;
    pgsv_pkg::t_out      r_out;

    logic                in_acc;
    logic [QW-1:0]       n_eff;
    logic [AW-1:0]       lowmask, pair_ext, pair_lo, pair_hi;
    logic [AW-1:0]       ram_raddr, ram_waddr;
    logic [WW-1:0]       ram_rdata, ram_wdata, new_lo;
    logic                ram_we;
    logic [AB-1:0]       hi_re, hi_im;
    logic                is_gate;

    always_comb begin
        if (r_qcnt == '0) begin
            n_eff = QW'(1);
        end else if (r_qcnt > pgsv_pkg::QCNT_MAX) begin
            n_eff = pgsv_pkg::QCNT_MAX;
        end else begin
            n_eff = r_qcnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) &&
                         (i_in.op != pgsv_pkg::OP_READ || !r_out_vld || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign is_gate     = (i_in.op == pgsv_pkg::OP_X) || (i_in.op == pgsv_pkg::OP_Y) ||
                         (i_in.op == pgsv_pkg::OP_Z);

    assign lowmask  = AW'((AW'(1) << r_q) - AW'(1));
    assign pair_ext = AW'(r_cnt);
    assign pair_lo  = AW'((pair_ext & ~lowmask) << 1) | (pair_ext & lowmask);
    assign pair_hi  = pair_lo | AW'(AW'(1) << r_q);

    assign ram_raddr = (r_state == S_GATE) ? (r_ph ? pair_hi : pair_lo) : i_in.address;

    assign hi_re = ram_rdata[WW-1:AB];
    assign hi_im = ram_rdata[AB-1:0];

    always_comb begin
        case (r_op)
            pgsv_pkg::OP_X: begin
                new_lo    = ram_rdata;
                n_wh_data = {r_lo_re, r_lo_im};
            end
            pgsv_pkg::OP_Y: begin
                new_lo    = {hi_im, pgsv_pkg::f_neg(hi_re)};
                n_wh_data = {pgsv_pkg::f_neg(r_lo_im), r_lo_re};
            end
            default: begin
                new_lo    = {r_lo_re, r_lo_im};
                n_wh_data = {pgsv_pkg::f_neg(hi_re), pgsv_pkg::f_neg(hi_im)};
            end
        endcase
    end

    always_comb begin
        if (r_wh_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_wh_addr;
            ram_wdata = r_wh_data;
        end else if (r_s1_vld && r_s1_ph) begin
            ram_we    = 1'b1;
            ram_waddr = r_lo_addr;
            ram_wdata = new_lo;
        end else begin
            ram_we    = in_acc && (i_in.op == pgsv_pkg::OP_LOAD);
            ram_waddr = i_in.address;
            ram_wdata = {i_in.real_in, i_in.imag_in};
        end
    end

    pgsv_ram #(
        .WIDTH (WW),
        .DEPTH (pgsv_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_ph      = r_ph;
        n_s1_vld  = 1'b0;
        n_s1_ph   = r_ph;
        n_s1_addr = ram_raddr;
        n_wh_vld  = r_s1_vld && r_s1_ph;
        n_out_vld = r_out_vld && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == pgsv_pkg::OP_READ) begin
                        n_state = S_RD;
                    end else if (is_gate && (i_in.qubit < n_eff)) begin
                        n_state = S_GATE;
                        n_op    = i_in.op;
                        n_q     = i_in.qubit;
                        n_cnt   = '0;
                        n_ph    = 1'b0;
                        n_last  = PW'((AW'(1) << (n_eff - QW'(1))) - AW'(1));
                    end
                end
            end
            S_RD: begin
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end
            S_GATE: begin
                n_s1_vld = 1'b1;
                n_ph     = !r_ph;
                if (r_ph) begin
                    if (r_cnt == r_last) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_cnt = PW'(r_cnt + PW'(1));
                    end
                end
            end
            S_DRAIN: begin
                if (!r_s1_vld && !r_wh_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qcnt    <= pgsv_pkg::QCNT_RESET;
            r_s1_vld  <= 1'b0;
            r_wh_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ph      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= n_s1_vld;
            r_wh_vld  <= n_wh_vld;
            r_out_vld <= n_out_vld;
            r_ph      <= n_ph;
            r_cnt     <= n_cnt;
            if (i_cfg_valid) begin
                r_qcnt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_q       <= n_q;
        r_last    <= n_last;
        r_s1_ph   <= n_s1_ph;
        r_s1_addr <= n_s1_addr;
        if (r_s1_vld && !r_s1_ph) begin
            r_lo_re   <= ram_rdata[WW-1:AB];
            r_lo_im   <= ram_rdata[AB-1:0];
            r_lo_addr <= r_s1_addr;
        end
        if (r_s1_vld && r_s1_ph) begin
            r_wh_addr <= r_s1_addr;
            r_wh_data <= n_wh_data;
        end
        if (r_state == S_RD) begin
            r_out.real_out <= ram_rdata[WW-1:AB];
            r_out.imag_out <= ram_rdata[AB-1:0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_wh_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wh_vld |-> (r_state != S_IDLE))
        else $error("Pending upper write while idle.");

    a_hi_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_ph) |=> r_wh_vld)
        else $error("Upper amplitude write was lost.");

    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_s1_vld && !r_wh_vld))
        else $error("Request accepted while the gate pipeline is busy.");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !r_out_vld)
        else $error("Read result would overwrite a pending result.");

    a_ph_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && $past(r_s1_vld)) |-> (r_s1_ph != $past(r_s1_ph)))
        else $error("Pair read phases do not alternate.");

endmodule

>>> sim/tb_pauli_gate_state_vector.sv
// ----------------------------------------------------------------------------
// Pauli gate state vector testbench
// Drives load, read, gate and unknown requests with random idling on both
// channels, writes the qubit count between phases, and checks every read
// result against a predictor that keeps its own copy of the state vector.
// ----------------------------------------------------------------------------
module tb_pauli_gate_state_vector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 8000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TARGET_ITEMS   = 450;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_PHASES     = 13;
    localparam int PHASE_QUBITS[NUM_PHASES] = '{3, 1, 0, 2, 4, 15, 5, 2, 10, 6, 1, 3, 7};

    localparam logic [pgsv_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [pgsv_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic signed [pgsv_pkg::AMP_BITS-1:0] AMP_MIN =
        {1'b1, {(pgsv_pkg::AMP_BITS-1){1'b0}}};
    localparam logic signed [pgsv_pkg::AMP_BITS-1:0] AMP_MAX =
        {1'b0, {(pgsv_pkg::AMP_BITS-1){1'b1}}};

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    pgsv_pkg::t_in               in_req = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    pgsv_pkg::t_out              out_res;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [pgsv_pkg::QCNT_W-1:0] cfg_data = '0;

    // Request stream and its expected read results.
    pgsv_pkg::t_in               req_pending_q[$];
    pgsv_pkg::t_out              read_expect_q[$];
    logic [pgsv_pkg::QCNT_W-1:0] qubit_writes_q[$];

    // Predictor state.
    logic signed [pgsv_pkg::AMP_BITS-1:0] amp_re[pgsv_pkg::MEM_DEPTH];
    logic signed [pgsv_pkg::AMP_BITS-1:0] amp_im[pgsv_pkg::MEM_DEPTH];
    logic [pgsv_pkg::QCNT_W-1:0]          vec_qubits = pgsv_pkg::QCNT_RESET;

    // Stimulus-side view of which entries hold a loaded value.
    bit amp_loaded[pgsv_pkg::MEM_DEPTH];
    int gen_n = pgsv_pkg::MAX_QUBITS;

    int  tx_gap = 0;
    int  rx_gap = 0;
    int  rx_hold_left = 0;
    int  rx_holds_requested = 0;
    int  rx_holds_done = 0;
    bit  no_gaps = 1'b0;
    int  stall_cycles = 0;
    int  err_count = 0;
    int  stim_count = 0;
    int  req_count = 0;
    int  reads_checked = 0;
    int  gate_count = 0;
    int  cfg_count = 0;

    pauli_gate_state_vector DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int eff_qubits(input logic [pgsv_pkg::QCNT_W-1:0] v);
        if (v < 1) return 1;
        if (v > pgsv_pkg::MAX_QUBITS) return pgsv_pkg::MAX_QUBITS;
        return int'(v);
    endfunction

    function automatic logic signed [pgsv_pkg::AMP_BITS-1:0] neg_sat(
        input logic signed [pgsv_pkg::AMP_BITS-1:0] v);
        return (v == AMP_MIN) ? AMP_MAX : -v;
    endfunction

    function automatic int pair_low(input int i, input int q);
        return ((i >> q) << (q + 1)) | (i & ((1 << q) - 1));
    endfunction

    function automatic int idle_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_amp();
        case ($urandom_range(0, 9))
            0: return int'(AMP_MIN);
            1: return int'(AMP_MAX);
            2: return 0;
            3: return -1;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    task automatic report_error(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    function automatic void apply_pauli(input logic [pgsv_pkg::OP_W-1:0] op, input int q);
        int n, lo, hi;
        logic signed [pgsv_pkg::AMP_BITS-1:0] lr, li, hr, hv;
        n = eff_qubits(vec_qubits);
        if (q >= n) return;
        for (int i = 0; i < (1 << (n - 1)); i++) begin
            lo = pair_low(i, q);
            hi = lo + (1 << q);
            lr = amp_re[lo];
            li = amp_im[lo];
            hr = amp_re[hi];
            hv = amp_im[hi];
            if (op == pgsv_pkg::OP_X) begin
                amp_re[lo] = hr;
                amp_im[lo] = hv;
                amp_re[hi] = lr;
                amp_im[hi] = li;
            end else if (op == pgsv_pkg::OP_Y) begin
                amp_re[lo] = hv;
                amp_im[lo] = neg_sat(hr);
                amp_re[hi] = neg_sat(li);
                amp_im[hi] = lr;
            end else begin
                amp_re[hi] = neg_sat(hr);
                amp_im[hi] = neg_sat(hv);
            end
        end
    endfunction

    function automatic void apply_request(input pgsv_pkg::t_in req);
        pgsv_pkg::t_out res;
        case (req.op)
            pgsv_pkg::OP_LOAD: begin
                amp_re[req.address] = req.real_in;
                amp_im[req.address] = req.imag_in;
            end
            pgsv_pkg::OP_READ: begin
                res.real_out = amp_re[req.address];
                res.imag_out = amp_im[req.address];
                read_expect_q.push_back(res);
            end
            pgsv_pkg::OP_X, pgsv_pkg::OP_Y, pgsv_pkg::OP_Z: begin
                gate_count++;
                apply_pauli(req.op, int'(req.qubit));
            end
            default: ;
        endcase
    endfunction

    // Request driver.
    always @(posedge clk) begin : req_driver
        pgsv_pkg::t_in nxt_req;
        logic          nxt_valid;
        int            nxt_gap;
        nxt_req   = in_req;
        nxt_valid = in_valid;
        nxt_gap   = tx_gap;
        if (!rst_n) begin
            nxt_valid = 1'b0;
            nxt_gap   = 0;
        end else begin
            if (in_valid && in_ready) begin
                apply_request(in_req);
                req_count++;
                nxt_valid = 1'b0;
                nxt_gap   = idle_gap();
            end
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (req_pending_q.size() > 0) begin
                    nxt_req   = req_pending_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        in_req   <= nxt_req;
        in_valid <= nxt_valid;
        tx_gap   <= nxt_gap;
    end

    // Qubit count writes.
    always @(posedge clk) begin : cfg_driver
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            vec_qubits = cfg_data;
            cfg_count++;
            cfg_valid <= 1'b0;
        end else if (!cfg_valid && qubit_writes_q.size() > 0) begin
            cfg_data  <= qubit_writes_q.pop_front();
            cfg_valid <= 1'b1;
        end
    end

    // Long receiver hold-off, counted here in cycles.
    always @(posedge clk) begin : rx_hold
        if (!rst_n) begin
            rx_hold_left  <= 0;
            rx_holds_done <= 0;
        end else if (rx_holds_done != rx_holds_requested) begin
            rx_holds_done <= rx_holds_requested;
            rx_hold_left  <= RX_HOLD_CYCLES;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Result monitor and receiver ready.
    always @(posedge clk) begin : result_monitor
        pgsv_pkg::t_out want;
        int             g;
        logic           rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end else begin
            g = rx_gap;
            if (out_ready && out_valid) begin
                if (read_expect_q.size() == 0) begin
                    report_error($sformatf("unexpected read result real %0d imag %0d",
                                           out_res.real_out, out_res.imag_out));
                end else begin
                    want = read_expect_q.pop_front();
                    reads_checked++;
                    if (out_res.real_out !== want.real_out) begin
                        report_error($sformatf("real_out expected %0d got %0d",
                                               want.real_out, out_res.real_out));
                    end
                    if (out_res.imag_out !== want.imag_out) begin
                        report_error($sformatf("imag_out expected %0d got %0d",
                                               want.imag_out, out_res.imag_out));
                    end
                end
                g = idle_gap();
            end
            if (rx_hold_left > 0) begin
                rdy = 1'b0;
            end else if (g > 0) begin
                g--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
            rx_gap    <= g;
        end
    end

    always @(posedge clk) begin : stall_counter
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("Timeout: no handshake for %0d cycles.", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_op(input logic [pgsv_pkg::OP_W-1:0] op, input int addr, input int re,
                           input int im, input int q);
        pgsv_pkg::t_in r;
        int            lo, hi;
        bit            tmp;
        r.op      = op;
        r.address = addr[pgsv_pkg::ADDR_W-1:0];
        r.real_in = re[pgsv_pkg::AMP_BITS-1:0];
        r.imag_in = im[pgsv_pkg::AMP_BITS-1:0];
        r.qubit   = q[pgsv_pkg::QCNT_W-1:0];
        req_pending_q.push_back(r);
        if (op == pgsv_pkg::OP_LOAD) begin
            amp_loaded[r.address] = 1'b1;
        end
        if ((op == pgsv_pkg::OP_X || op == pgsv_pkg::OP_Y) && q < gen_n) begin
            for (int i = 0; i < (1 << (gen_n - 1)); i++) begin
                lo = pair_low(i, q);
                hi = lo + (1 << q);
                tmp = amp_loaded[lo];
                amp_loaded[lo] = amp_loaded[hi];
                amp_loaded[hi] = tmp;
            end
        end
        if (op == pgsv_pkg::OP_LOAD || op == pgsv_pkg::OP_READ
                || ((op == pgsv_pkg::OP_X || op == pgsv_pkg::OP_Y || op == pgsv_pkg::OP_Z)
                    && q < gen_n)) begin
            stim_count++;
        end
    endtask

    // Reads a random loaded entry below span, or at times anywhere in the memory, if there is one.
    task automatic read_loaded(input int span);
        int start, a;
        if ($urandom_range(0, 7) == 0) span = pgsv_pkg::MEM_DEPTH;
        start = $urandom_range(0, span - 1);
        for (int k = 0; k < span; k++) begin
            a = (start + k) % span;
            if (amp_loaded[a]) begin
                push_op(pgsv_pkg::OP_READ, a, rand_amp(), rand_amp(), $urandom_range(0, 15));
                return;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (req_pending_q.size() != 0 || in_valid || read_expect_q.size() != 0);
        // A gate leaves no result behind, so give it time to finish.
        repeat ((1 << gen_n) + 8) @(negedge clk);
    endtask

    task automatic write_qubits(input int v);
        wait_drained();
        qubit_writes_q.push_back(v[pgsv_pkg::QCNT_W-1:0]);
        do @(negedge clk);
        while (qubit_writes_q.size() != 0 || cfg_valid);
        gen_n = eff_qubits(v[pgsv_pkg::QCNT_W-1:0]);
    endtask

    task automatic well_formed_episode();
        int span, nloads, ngates;
        logic [pgsv_pkg::OP_W-1:0] op;
        span   = 1 << gen_n;
        nloads = (span <= 16) ? span : $urandom_range(6, 16);
        for (int k = 0; k < nloads; k++) begin
            push_op(pgsv_pkg::OP_LOAD, (span <= 16) ? k : $urandom_range(0, span - 1),
                    rand_amp(), rand_amp(), $urandom_range(0, 15));
        end
        if ($urandom_range(0, 3) == 0) begin
            push_op(pgsv_pkg::OP_LOAD, $urandom_range(0, pgsv_pkg::MEM_DEPTH - 1),
                    rand_amp(), rand_amp(), $urandom_range(0, 15));
        end
        ngates = $urandom_range(1, 4);
        for (int k = 0; k < ngates; k++) begin
            op = pgsv_pkg::OP_X + pgsv_pkg::OP_W'($urandom_range(0, 2));
            push_op(op, $urandom_range(0, pgsv_pkg::MEM_DEPTH - 1), rand_amp(), rand_amp(),
                    $urandom_range(0, gen_n - 1));
            if ($urandom_range(0, 1) == 1) read_loaded(span);
        end
        repeat ($urandom_range(3, 8)) read_loaded(span);
    endtask

    task automatic noise_episode();
        logic [pgsv_pkg::OP_W-1:0] op;
        repeat ($urandom_range(4, 8)) begin
            op = pgsv_pkg::OP_W'($urandom_range(0, 7));
            if (op == pgsv_pkg::OP_READ) begin
                read_loaded(pgsv_pkg::MEM_DEPTH);
            end else begin
                push_op(op, $urandom_range(0, pgsv_pkg::MEM_DEPTH - 1), rand_amp(),
                        rand_amp(), $urandom_range(0, 15));
            end
        end
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Full vector after reset: extremes, saturating Z, swap, out-of-range gates.
        push_op(pgsv_pkg::OP_LOAD, 0, int'(AMP_MAX), int'(AMP_MIN), 0);
        push_op(pgsv_pkg::OP_LOAD, pgsv_pkg::MEM_DEPTH - 1, int'(AMP_MIN), int'(AMP_MAX), 0);
        push_op(pgsv_pkg::OP_LOAD, 512, -1, 1, 0);
        push_op(pgsv_pkg::OP_READ, 0, 0, 0, 0);
        push_op(pgsv_pkg::OP_READ, pgsv_pkg::MEM_DEPTH - 1, 0, 0, 0);
        push_op(pgsv_pkg::OP_Z, 0, 0, 0, 9);
        push_op(pgsv_pkg::OP_READ, pgsv_pkg::MEM_DEPTH - 1, 0, 0, 0);
        push_op(pgsv_pkg::OP_READ, 512, 0, 0, 0);
        push_op(pgsv_pkg::OP_X, 0, 0, 0, 9);
        push_op(pgsv_pkg::OP_READ, 0, 0, 0, 0);
        push_op(pgsv_pkg::OP_X, 0, 0, 0, 10);
        push_op(pgsv_pkg::OP_Z, 0, 0, 0, 15);
        push_op(OP_UNUSED_FIRST, pgsv_pkg::MEM_DEPTH - 1, -1, -1, 15);
        push_op(OP_UNUSED_LAST, 0, 0, 0, 0);

        // Two-qubit vector plus an entry beyond it.
        write_qubits(2);
        push_op(pgsv_pkg::OP_LOAD, 0, int'(AMP_MAX), int'(AMP_MIN), 0);
        push_op(pgsv_pkg::OP_LOAD, 1, int'(AMP_MIN), 0, 0);
        push_op(pgsv_pkg::OP_LOAD, 2, 1234, -1, 0);
        push_op(pgsv_pkg::OP_LOAD, 3, 0, int'(AMP_MAX), 0);
        push_op(pgsv_pkg::OP_LOAD, 1000, int'(AMP_MIN), int'(AMP_MIN), 0);
        push_op(pgsv_pkg::OP_Y, 0, 0, 0, 1);
        push_op(pgsv_pkg::OP_Y, 0, 0, 0, 0);
        push_op(pgsv_pkg::OP_Z, 0, 0, 0, 1);
        push_op(pgsv_pkg::OP_Z, 0, 0, 0, 2);
        for (int a = 0; a < 4; a++) push_op(pgsv_pkg::OP_READ, a, 0, 0, 0);
        push_op(pgsv_pkg::OP_READ, 1000, 0, 0, 0);

        stim_count = 0;
        for (int phase = 0; stim_count < TARGET_ITEMS; phase++) begin
            write_qubits(PHASE_QUBITS[phase % NUM_PHASES]);
            no_gaps = (phase % 4 == 3);
            if (phase == 0) begin
                // Results back up while the receiver holds off.
                for (int a = 0; a < (1 << gen_n); a++) begin
                    push_op(pgsv_pkg::OP_LOAD, a, rand_amp(), rand_amp(), 0);
                end
                rx_holds_requested++;
                repeat (24) read_loaded(1 << gen_n);
            end
            phase_start = stim_count;
            while (stim_count - phase_start < 40) begin
                if ($urandom_range(0, 4) == 0) noise_episode();
                else well_formed_episode();
            end
        end
        wait_drained();
        no_gaps = 1'b0;

        $display("Ran %0d requests with %0d gates and %0d checked reads over %0d qubit counts.",
                 req_count, gate_count, reads_checked, cfg_count);
        $display("Mismatches: %0d.", err_count);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
